### rtl/decimal_expression_alu_macros.svh
// Assertion helpers for the decimal expression ALU.
`ifndef DECIMAL_EXPRESSION_ALU_MACROS_SVH
`define DECIMAL_EXPRESSION_ALU_MACROS_SVH

`ifndef SYNTHESIS
// prop holds at every clock edge outside reset
`define DEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// cond never holds outside reset
`define DEA_ASSERT_NEVER(lbl, cond, msg) \
  `DEA_ASSERT(lbl, !(cond), msg)
`else
`define DEA_ASSERT(lbl, prop, msg)
`define DEA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/dea_pkg.sv
package dea_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_WS1   = 4'd0,
    PH_SIGN1 = 4'd1,
    PH_NUM1  = 4'd2,
    PH_WS2   = 4'd3,
    PH_SIGN2 = 4'd4,
    PH_NUM2  = 4'd5,
    PH_DONE  = 4'd6,
    PH_FAIL  = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_DIVZ = 2'd2,
    STAT_UNK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEQ_PARSE,
    SEQ_EVAL,
    SEQ_ISSUE,
    SEQ_WAIT,
    SEQ_OUT
  } seq_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value;
    status_e                     status;
  } out_t;

  typedef struct packed {
    logic                 start;
    logic                 op_div;
    logic [WORD_BITS-1:0] opa;
    logic [WORD_BITS-1:0] opb;
  } iter_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] value;
  } iter_rsp_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc * 10 + digit, wrapping; digit value is the low nibble of an ASCII digit
  function automatic logic [WORD_BITS-1:0] push_digit(logic [WORD_BITS-1:0] acc,
                                                      logic [7:0] c);
    return (acc << 3) + (acc << 1) + {{(WORD_BITS-4){1'b0}}, c[3:0]};
  endfunction

endpackage

### rtl/dea_iter.sv
module dea_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dea_pkg::iter_req_t  req_i,
  output dea_pkg::iter_rsp_t  rsp_o
);

  localparam int W = dea_pkg::WORD_BITS;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic                      div_q, div_d;
  logic [dea_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]              acc_q, acc_d;
  logic [W-1:0]              x_q, x_d;
  logic [W-1:0]              y_q, y_d;
  logic [W-1:0]              trial;

  // multiply: acc += x when y lsb set, x shifts up, y shifts down (low word only)
  // divide: restoring, acc is the remainder, x the dividend turning into the quotient
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    trial  = {acc_q[W-2:0], x_q[W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.op_div;
      cnt_d  = dea_pkg::CNT_W'(W - 1);
      acc_d  = '0;
      x_d    = req_i.opa;
      y_d    = req_i.opb;
    end else if (busy_q) begin
      if (div_q) begin
        if (trial >= y_q) begin
          acc_d = trial - y_q;
          x_d   = {x_q[W-2:0], 1'b1};
        end else begin
          acc_d = trial;
          x_d   = {x_q[W-2:0], 1'b0};
        end
      end else begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = x_q << 1;
        y_d = y_q >> 1;
      end
      cnt_d = cnt_q - dea_pkg::CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = div_q ? x_q : acc_q;

endmodule

### rtl/decimal_expression_alu.sv
// Four-function integer calculator. Characters of an expression such as
// " -12* +7" arrive one per request on the input channel and are parsed at
// one character per cycle as signed integer, one operator character, signed
// integer; text after the second number is ignored. The request flagged
// end_of_text yields one result: value plus status (ok, bad format, divide by
// zero, unknown operator; value is 0 unless ok). After that final character
// the input stalls while the result is computed: an evaluate state, then for
// + and - an issue state, and for * and / an issue state and a wait on the
// shared shift-add / restoring-divide unit that retires one bit per cycle;
// a bad format, divide by zero or unknown operator goes from evaluate straight
// to the output state, which waits while the previous result is still held
// in the output register. A held result does not block the characters of the
// next expression, only its final character's evaluation.
`include "decimal_expression_alu_macros.svh"

module decimal_expression_alu (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dea_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dea_pkg::out_t  out_o
);

  localparam int W = dea_pkg::WORD_BITS;

  dea_pkg::seq_e    seq_q, seq_d;
  dea_pkg::phase_e  phase_q, phase_d;
  logic [W-1:0]     num1_q, num1_d;
  logic [W-1:0]     num2_q, num2_d;
  logic             neg1_q, neg1_d;
  logic             neg2_q, neg2_d;
  logic [7:0]       op_q, op_d;

  dea_pkg::status_e status_q, status_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     res_q, res_d;
  logic             qneg_q, qneg_d;

  logic             out_valid_q, out_valid_d;
  dea_pkg::out_t    out_q, out_d;

  dea_pkg::iter_req_t iter_req;
  dea_pkg::iter_rsp_t iter_rsp;

  logic             in_acc;
  logic             out_free;
  logic             parse_clear;
  logic [7:0]       c;
  logic [W-1:0]     abs_a, abs_b;

  assign in_stall_o = (seq_q != dea_pkg::SEQ_PARSE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign c          = in_i.char_code;
  assign abs_a      = a_q[W-1] ? (W'(0) - a_q) : a_q;
  assign abs_b      = b_q[W-1] ? (W'(0) - b_q) : b_q;

  // character parser
  always_comb begin
    phase_d = phase_q;
    num1_d  = num1_q;
    num2_d  = num2_q;
    neg1_d  = neg1_q;
    neg2_d  = neg2_q;
    op_d    = op_q;
    if (parse_clear) begin
      phase_d = dea_pkg::PH_WS1;
      num1_d  = '0;
      num2_d  = '0;
      neg1_d  = 1'b0;
      neg2_d  = 1'b0;
      op_d    = '0;
    end else if (in_acc && phase_q != dea_pkg::PH_DONE && phase_q != dea_pkg::PH_FAIL) begin
      if (c == dea_pkg::CH_NUL) begin
        phase_d = (phase_q == dea_pkg::PH_NUM2) ? dea_pkg::PH_DONE : dea_pkg::PH_FAIL;
      end else begin
        case (phase_q)
          dea_pkg::PH_WS1: begin
            if (dea_pkg::is_space(c)) begin
              phase_d = phase_q;
            end else if (c == dea_pkg::CH_PLUS || c == dea_pkg::CH_MINUS) begin
              neg1_d  = (c == dea_pkg::CH_MINUS);
              phase_d = dea_pkg::PH_SIGN1;
            end else if (dea_pkg::is_digit(c)) begin
              num1_d  = dea_pkg::push_digit(num1_q, c);
              phase_d = dea_pkg::PH_NUM1;
            end else begin
              phase_d = dea_pkg::PH_FAIL;
            end
          end
          dea_pkg::PH_SIGN1: begin
            if (dea_pkg::is_digit(c)) begin
              num1_d  = dea_pkg::push_digit(num1_q, c);
              phase_d = dea_pkg::PH_NUM1;
            end else begin
              phase_d = dea_pkg::PH_FAIL;
            end
          end
          dea_pkg::PH_NUM1: begin
            if (dea_pkg::is_digit(c)) begin
              num1_d = dea_pkg::push_digit(num1_q, c);
            end else begin
              op_d    = c;
              phase_d = dea_pkg::PH_WS2;
            end
          end
          dea_pkg::PH_WS2: begin
            if (dea_pkg::is_space(c)) begin
              phase_d = phase_q;
            end else if (c == dea_pkg::CH_PLUS || c == dea_pkg::CH_MINUS) begin
              neg2_d  = (c == dea_pkg::CH_MINUS);
              phase_d = dea_pkg::PH_SIGN2;
            end else if (dea_pkg::is_digit(c)) begin
              num2_d  = dea_pkg::push_digit(num2_q, c);
              phase_d = dea_pkg::PH_NUM2;
            end else begin
              phase_d = dea_pkg::PH_FAIL;
            end
          end
          dea_pkg::PH_SIGN2: begin
            if (dea_pkg::is_digit(c)) begin
              num2_d  = dea_pkg::push_digit(num2_q, c);
              phase_d = dea_pkg::PH_NUM2;
            end else begin
              phase_d = dea_pkg::PH_FAIL;
            end
          end
          dea_pkg::PH_NUM2: begin
            if (dea_pkg::is_digit(c)) begin
              num2_d = dea_pkg::push_digit(num2_q, c);
            end else begin
              phase_d = dea_pkg::PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // evaluation sequencer
  always_comb begin
    seq_d       = seq_q;
    status_d    = status_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    qneg_d      = qneg_q;
    parse_clear = 1'b0;
    iter_req    = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (seq_q)
      dea_pkg::SEQ_PARSE: begin
        if (in_acc && in_i.end_of_text) begin
          seq_d = dea_pkg::SEQ_EVAL;
        end
      end
      dea_pkg::SEQ_EVAL: begin
        a_d   = neg1_q ? (W'(0) - num1_q) : num1_q;
        b_d   = neg2_q ? (W'(0) - num2_q) : num2_q;
        res_d = '0;
        seq_d = dea_pkg::SEQ_OUT;
        if (phase_q != dea_pkg::PH_NUM2 && phase_q != dea_pkg::PH_DONE) begin
          status_d = dea_pkg::STAT_BAD;
        end else if (op_q == dea_pkg::CH_PLUS || op_q == dea_pkg::CH_MINUS ||
                     op_q == dea_pkg::CH_STAR) begin
          status_d = dea_pkg::STAT_OK;
          seq_d    = dea_pkg::SEQ_ISSUE;
        end else if (op_q == dea_pkg::CH_SLASH) begin
          // negation keeps zero at zero, so the magnitude tells
          if (num2_q == '0) begin
            status_d = dea_pkg::STAT_DIVZ;
          end else begin
            status_d = dea_pkg::STAT_OK;
            seq_d    = dea_pkg::SEQ_ISSUE;
          end
        end else begin
          status_d = dea_pkg::STAT_UNK;
        end
      end
      dea_pkg::SEQ_ISSUE: begin
        if (op_q == dea_pkg::CH_PLUS) begin
          res_d = a_q + b_q;
          seq_d = dea_pkg::SEQ_OUT;
        end else if (op_q == dea_pkg::CH_MINUS) begin
          res_d = a_q - b_q;
          seq_d = dea_pkg::SEQ_OUT;
        end else if (op_q == dea_pkg::CH_STAR) begin
          iter_req.start  = 1'b1;
          iter_req.op_div = 1'b0;
          iter_req.opa    = a_q;
          iter_req.opb    = b_q;
          seq_d           = dea_pkg::SEQ_WAIT;
        end else begin
          iter_req.start  = 1'b1;
          iter_req.op_div = 1'b1;
          iter_req.opa    = abs_a;
          iter_req.opb    = abs_b;
          qneg_d          = a_q[W-1] ^ b_q[W-1];
          seq_d           = dea_pkg::SEQ_WAIT;
        end
      end
      dea_pkg::SEQ_WAIT: begin
        if (iter_rsp.done) begin
          if (op_q == dea_pkg::CH_SLASH && qneg_q) begin
            res_d = W'(0) - iter_rsp.value;
          end else begin
            res_d = iter_rsp.value;
          end
          seq_d = dea_pkg::SEQ_OUT;
        end
      end
      dea_pkg::SEQ_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.value  = $signed(res_q);
          out_d.status = status_q;
          parse_clear  = 1'b1;
          seq_d        = dea_pkg::SEQ_PARSE;
        end
      end
      default: begin
        seq_d = dea_pkg::SEQ_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= dea_pkg::SEQ_PARSE;
      phase_q     <= dea_pkg::PH_WS1;
      num1_q      <= '0;
      num2_q      <= '0;
      neg1_q      <= 1'b0;
      neg2_q      <= 1'b0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      num1_q      <= num1_d;
      num2_q      <= num2_d;
      neg1_q      <= neg1_d;
      neg2_q      <= neg2_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    qneg_q   <= qneg_d;
    out_q    <= out_d;
  end

  dea_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `DEA_ASSERT(a_err_value_zero, out_valid_o && out_o.status != dea_pkg::STAT_OK |-> out_o.value == '0, "error result with nonzero value")
  `DEA_ASSERT(a_last_char_stalls, in_acc && in_i.end_of_text |=> in_stall_o, "input not stalled after final character")
  `DEA_ASSERT_NEVER(a_done_outside_wait, iter_rsp.done && seq_q != dea_pkg::SEQ_WAIT, "shared unit finished outside wait")
  `DEA_ASSERT(a_load_from_out, out_valid_o && !$past(out_valid_o) |-> $past(seq_q == dea_pkg::SEQ_OUT), "result appeared without sequencer")
  `DEA_ASSERT(a_parse_reset, seq_q == dea_pkg::SEQ_OUT && out_free |=> phase_q == dea_pkg::PH_WS1 && num1_q == '0 && num2_q == '0, "parser not cleared after result")

endmodule
